// ----- hdl/ipvcr_pkg.sv -----
`timescale 1ns / 1ps
package ipvcr_pkg;

  localparam int WAYS_DEF = 16;
  localparam int SETS_DEF = 64;

  // field widths
  localparam int OP_W   = 2;
  localparam int SIDX_W = 6;
  localparam int WAYF_W = 4;
  localparam int POS_W  = 5;
  localparam int PV_W   = 64;
  localparam int INS_W  = 4;
  localparam int PV_ENT_W = 4;

  localparam logic [POS_W-1:0] POS_MAX   = 5'd31;
  localparam logic [INS_W-1:0] INS_RESET = 4'd13;
  localparam logic [PV_W-1:0]  PV_RESET  = '0;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = OP_W;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = PV_W;

  typedef enum logic [OP_W-1:0] {
    OP_HIT    = 2'd0,
    OP_FILL   = 2'd1,
    OP_VICTIM = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROMO_VEC  = 1'b0,
    CFG_INSERT_POS = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  // request handed to the row update logic
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [WAYF_W-1:0] way;
    logic              ok;    // operation in range and legal
  } ipvcr_req_t;

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] p);
    sat_inc = (p == POS_MAX) ? POS_MAX : p + POS_W'(1);
  endfunction

endpackage

// ----- hdl/ipv_cache_replacement_core.sv -----
`timescale 1ns / 1ps
// replacement state for a set-associative cache, one recency row per set
// input channel (in_*): one operation per transfer; in_tuser carries the op
// (hit promote, fill insert, victim query), in_tdata the set and the way
// output channel (out_*): exactly one result per operation, in order,
// carrying the victim way and the new position of the touched way
// configuration channel (cfg_*): index 0 promotion vector, 1 insertion
// position; write only while no operation is in flight
// an input transfer reads the set row into the update stage, and the output
// register takes the result when that stage advances
// throughput: one operation per cycle unless the output stalls; each set row is read
// from a memory with one read and one write port, updated and written back when the
// update stage advances, and a back-to-back access to the same set takes the row from forwarding
// reset: a clearing pass writes every row to zero, and in_tready stays low until
// it ends; cfg writes are taken throughout
// stall: a single output register holds a result until out_tready; while
// it is full and not taken, the update stage holds its operation and
// in_tready drops as soon as that stage is occupied
module ipv_cache_replacement_core #(
  parameter int WAYS = ipvcr_pkg::WAYS_DEF,
  parameter int SETS = ipvcr_pkg::SETS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [ipvcr_pkg::IN_TDATA_W-1:0]      in_tdata,   // set_index[5:0], way[9:6], zero
  input  logic [ipvcr_pkg::IN_TUSER_W-1:0]      in_tuser,   // op[1:0]
  // result channel
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [ipvcr_pkg::OUT_TDATA_W-1:0]     out_tdata,  // victim_way[3:0], new_position[8:4], zero
  // configuration channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ipvcr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ipvcr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ipvcr_pkg::*;

  localparam int WAY_W  = $clog2(WAYS);
  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int AW     = (SET_W > SIDX_W) ? SET_W : SIDX_W;
  localparam int POSF_W = WAYS * POS_W;
  localparam int ROW_W  = POSF_W + WAYS;

  // row memory: valid bits on top, positions below
  logic [ROW_W-1:0] row_mem [SETS];
  logic [ROW_W-1:0] rd_data_r;

  state_t state_r, state_nxt;
  logic [SET_W-1:0] clr_cnt_r;

  logic [PV_W-1:0]  promo_vec_r;
  logic [INS_W-1:0] ins_pos_r;

  // input decode
  logic [SIDX_W-1:0] in_set;
  logic [WAYF_W-1:0] in_way;
  logic [AW-1:0]     in_set_ext;
  logic [SET_W-1:0]  in_addr;
  logic              in_range;
  logic              in_acc;
  ipvcr_req_t        in_req;

  // update stage
  logic              s1_valid_r;
  logic              s1_range_r;
  logic [SET_W-1:0]  s1_addr_r;
  ipvcr_req_t        s1_req_r;
  logic              s1_adv;
  logic              s1_wr;
  logic              fwd_hit_r;
  logic [ROW_W-1:0]  fwd_row_r;
  logic [ROW_W-1:0]  cur_row;
  logic [ROW_W-1:0]  new_row;
  logic [WAYS-1:0][POS_W-1:0] cur_pos, new_pos_row;
  logic [WAYS-1:0]   cur_vld, new_vld;
  logic [WAYF_W-1:0] upd_victim;
  logic [POS_W-1:0]  upd_pos;

  // output register
  logic              out_valid_r;
  logic [WAYF_W-1:0] out_victim_r;
  logic [POS_W-1:0]  out_pos_r;

  assign in_set     = in_tdata[SIDX_W-1:0];
  assign in_way     = in_tdata[SIDX_W +: WAYF_W];
  assign in_set_ext = AW'(in_set);
  assign in_addr    = in_set_ext[SET_W-1:0];
  assign in_range   = (32'(in_set) < 32'(SETS));

  always_comb begin
    in_req.op  = in_tuser;
    in_req.way = in_way;
    unique case (in_tuser)
      OP_HIT, OP_FILL: in_req.ok = in_range && (32'(in_way) < 32'(WAYS));
      OP_VICTIM:       in_req.ok = in_range;
      default:         in_req.ok = 1'b0;   // unused opcode: no change, zero result
    endcase
  end

  // update stage moves on whenever the output register is free or draining
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_RUN) && (!s1_valid_r || s1_adv);
  assign in_acc    = in_tvalid && in_tready;
  assign s1_wr     = s1_valid_r && s1_adv && s1_range_r;

  // clear sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_cnt_r == SET_W'(SETS - 1)) state_nxt = ST_RUN;
      ST_RUN:   state_nxt = ST_RUN;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + SET_W'(1);
    end
  end

  // row memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR)
      row_mem[clr_cnt_r] <= '0;
    else if (s1_wr)
      row_mem[s1_addr_r] <= new_row;
    if (in_acc)
      rd_data_r <= row_mem[in_addr];
  end

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      promo_vec_r <= PV_RESET;
      ins_pos_r   <= INS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PROMO_VEC:  promo_vec_r <= cfg_data;
        CFG_INSERT_POS: ins_pos_r   <= cfg_data[INS_W-1:0];
        default:        ;
      endcase
    end
  end

  // stage register; forwarding covers a write landing on the same edge as the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
      fwd_hit_r  <= s1_wr && (s1_addr_r == in_addr);
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_range_r <= in_range;
      s1_addr_r  <= in_addr;
      s1_req_r   <= in_req;
      fwd_row_r  <= new_row;
    end
  end

  assign cur_row = fwd_hit_r ? fwd_row_r : rd_data_r;
  assign cur_pos = cur_row[POSF_W-1:0];
  assign cur_vld = cur_row[ROW_W-1:POSF_W];
  assign new_row = {new_vld, new_pos_row};

  ipvcr_row_update #(
    .WAYS  (WAYS),
    .WAY_W (WAY_W)
  ) u_row_update (
    .req        (s1_req_r),
    .promo_vec  (promo_vec_r),
    .ins_pos    (ins_pos_r),
    .pos_in     (cur_pos),
    .vld_in     (cur_vld),
    .pos_out    (new_pos_row),
    .vld_out    (new_vld),
    .victim_way (upd_victim),
    .new_pos    (upd_pos)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_victim_r <= upd_victim;
      out_pos_r    <= upd_pos;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_pos_r, out_victim_r});

endmodule

// ----- hdl/ipvcr_row_update.sv -----
`timescale 1ns / 1ps
module ipvcr_row_update #(
  parameter int WAYS  = ipvcr_pkg::WAYS_DEF,
  parameter int WAY_W = $clog2(WAYS)
) (
  input  ipvcr_pkg::ipvcr_req_t                              req,
  input  logic [ipvcr_pkg::PV_W-1:0]                         promo_vec,
  input  logic [ipvcr_pkg::INS_W-1:0]                        ins_pos,
  input  logic [WAYS-1:0][ipvcr_pkg::POS_W-1:0]              pos_in,
  input  logic [WAYS-1:0]                                    vld_in,
  output logic [WAYS-1:0][ipvcr_pkg::POS_W-1:0]              pos_out,
  output logic [WAYS-1:0]                                    vld_out,
  output logic [ipvcr_pkg::WAYF_W-1:0]                       victim_way,
  output logic [ipvcr_pkg::POS_W-1:0]                        new_pos
);
  import ipvcr_pkg::*;

  localparam int NP = 1 << WAY_W;

  logic [WAY_W-1:0]    widx;
  logic [POS_W-1:0]    old_pos;
  logic [PV_ENT_W-1:0] pv_sel;
  logic [POS_W-1:0]    hit_pos;
  logic [POS_W-1:0]    ins_ext;
  logic                hit_ok;
  logic [POS_W-1:0]    tp [NP];
  logic [WAYF_W-1:0]   tw [NP];

  assign widx    = req.way[WAY_W-1:0];
  assign old_pos = pos_in[widx];
  // positions of 16 and up share the last entry
  assign pv_sel  = (old_pos > POS_W'(15)) ? PV_ENT_W'(15) : old_pos[PV_ENT_W-1:0];
  assign hit_pos = POS_W'(promo_vec[pv_sel*PV_ENT_W +: PV_ENT_W]);
  assign ins_ext = POS_W'(ins_pos);
  assign hit_ok  = req.ok && (req.op == OP_HIT) && vld_in[widx];

  always_comb begin
    pos_out = pos_in;
    vld_out = vld_in;
    new_pos = '0;
    if (hit_ok) begin
      for (int i = 0; i < WAYS; i++) begin
        if (WAY_W'(i) != widx && vld_in[i] && pos_in[i] >= hit_pos && pos_in[i] < old_pos)
          pos_out[i] = sat_inc(pos_in[i]);
      end
      pos_out[widx] = hit_pos;
      new_pos       = hit_pos;
    end else if (req.ok && req.op == OP_FILL) begin
      for (int i = 0; i < WAYS; i++) begin
        if (vld_in[i] && pos_in[i] >= ins_ext)
          pos_out[i] = sat_inc(pos_in[i]);
      end
      pos_out[widx] = ins_ext;
      vld_out[widx] = 1'b1;
      new_pos       = ins_ext;
    end
  end

  // max tree, lower way wins ties, all-zero picks way 0
  always_comb begin
    for (int i = 0; i < NP; i++) begin
      tp[i] = '0;
      tw[i] = WAYF_W'(i);
    end
    for (int i = 0; i < WAYS; i++) begin
      tp[i] = vld_in[i] ? pos_in[i] : '0;
    end
    for (int l = 0; l < WAY_W; l++) begin
      for (int i = 0; i < (NP >> (l + 1)); i++) begin
        if (tp[2*i+1] > tp[2*i]) begin
          tp[i] = tp[2*i+1];
          tw[i] = tw[2*i+1];
        end else begin
          tp[i] = tp[2*i];
          tw[i] = tw[2*i];
        end
      end
    end
    victim_way = (req.ok && req.op == OP_VICTIM) ? tw[0] : '0;
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import ipvcr_pkg::*;

  localparam int N_WAYS = WAYS_DEF;
  localparam int N_SETS = SETS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 7;
  localparam int ITEMS_PER_PHASE = 236;
  localparam int HOLD_AT = 500;       // result count at which the receiver backs off
  localparam int HOLD_CYCLES = 240;
  localparam int DRAIN_CYCLES = 4;    // length of the idle tail at the end of drain
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  typedef struct packed {
    logic [WAYF_W-1:0] victim;
    logic [POS_W-1:0]  newpos;
  } outcome_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SIDX_W-1:0] set_idx;
    logic [WAYF_W-1:0] way;
    bit                typed;   // outcome typed in below instead of predicted
    outcome_t          outcome;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow of the replacement state and the registers
  logic [POS_W-1:0] way_pos [N_SETS][N_WAYS];
  bit               way_vld [N_SETS][N_WAYS];
  logic [PV_W-1:0]  promo_vec = PV_RESET;
  logic [INS_W-1:0] ins_pos = INS_RESET;

  outcome_t  awaited[$];
  stim_row_t dir_rows[$];
  int        fail_count = 0;
  int        n_received = 0;
  int        cycle_cnt = 0;
  bit        tx_burst = 1'b0;
  bit        rx_burst = 1'b0;

  ipv_cache_replacement_core #(
    .WAYS(N_WAYS),
    .SETS(N_SETS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // set_index[5:0], way[9:6], zero
    .in_tuser  (in_tuser),   // op[1:0]
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // victim_way[3:0], new_position[8:4], zero
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[ipv_cache_replacement_core] ERROR");
      $finish;
    end
  end

  // one step down toward eviction, saturating
  function automatic logic [POS_W-1:0] age_up(input logic [POS_W-1:0] p);
    return (p == POS_MAX) ? p : p + POS_W'(1);
  endfunction

  // applies one operation to the shadow state, returns the outcome it yields
  function automatic outcome_t predict_outcome(input logic [OP_W-1:0] op,
                                               input logic [SIDX_W-1:0] set_idx,
                                               input logic [WAYF_W-1:0] way);
    outcome_t         r;
    logic [POS_W-1:0] old_p;
    logic [POS_W-1:0] np;
    logic [POS_W-1:0] best;
    int               k;
    r = '0;
    if (int'(set_idx) >= N_SETS) return r;
    if (op == OP_HIT) begin
      if (int'(way) < N_WAYS && way_vld[set_idx][way]) begin
        old_p = way_pos[set_idx][way];
        k = (old_p > 5'd15) ? 15 : int'(old_p);
        np = {1'b0, promo_vec[4*k +: PV_ENT_W]};
        // ways between the new and old position move down, hit way excluded
        for (int i = 0; i < N_WAYS; i++) begin
          if (i != int'(way) && way_vld[set_idx][i] &&
              way_pos[set_idx][i] >= np && way_pos[set_idx][i] < old_p)
            way_pos[set_idx][i] = age_up(way_pos[set_idx][i]);
        end
        way_pos[set_idx][way] = np;
        r.newpos = np;
      end
    end else if (op == OP_FILL) begin
      if (int'(way) < N_WAYS) begin
        np = {1'b0, ins_pos};
        for (int i = 0; i < N_WAYS; i++) begin
          if (way_vld[set_idx][i] && way_pos[set_idx][i] >= np)
            way_pos[set_idx][i] = age_up(way_pos[set_idx][i]);
        end
        way_pos[set_idx][way] = np;
        way_vld[set_idx][way] = 1'b1;
        r.newpos = np;
      end
    end else if (op == OP_VICTIM) begin
      best = '0;
      for (int i = 0; i < N_WAYS; i++) begin
        if (way_vld[set_idx][i] && way_pos[set_idx][i] > best) begin
          best = way_pos[set_idx][i];
          r.victim = WAYF_W'(i);
        end
      end
    end
    return r;
  endfunction

  function automatic void add_row(input logic [OP_W-1:0] op, input int set_idx,
                                  input int way, input bit typed,
                                  input int victim, input int newpos);
    stim_row_t row;
    row.op = op;
    row.set_idx = SIDX_W'(set_idx);
    row.way = WAYF_W'(way);
    row.typed = typed;
    row.outcome.victim = WAYF_W'(victim);
    row.outcome.newpos = POS_W'(newpos);
    dir_rows.push_back(row);
  endfunction

  // one input transfer; valid stays up between back-to-back items
  task automatic send_op(input logic [OP_W-1:0] op, input logic [SIDX_W-1:0] set_idx,
                         input logic [WAYF_W-1:0] way, input bit typed,
                         input outcome_t typed_out);
    int       gap;
    outcome_t pred;
    gap = tx_burst ? 0 : int'($urandom_range(0, 13));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {6'd0, way, set_idx};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    pred = predict_outcome(op, set_idx, way);
    awaited.push_back(typed ? typed_out : pred);
  endtask

  // stop offering, let every outstanding result come back, then hold idle for the drain tail
  task automatic drain;
    in_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // two register transfers back to back, valid held across them
  task automatic program_regs(input logic [PV_W-1:0] pv, input logic [INS_W-1:0] ins);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_PROMO_VEC;
    cfg_data <= pv;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    promo_vec = pv;
    cfg_index <= CFG_INSERT_POS;
    cfg_data <= {{(CFG_DATA_W-INS_W){1'b0}}, ins};
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    ins_pos = ins;
    cfg_valid <= 1'b0;
  endtask

  // result side: random back-pressure, one long hold-off, in-order compare
  initial begin
    int       gap;
    bit       held;
    outcome_t exp_o;
    held = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = rx_burst ? 0 : int'($urandom_range(0, 13));
      if (!held && n_received == HOLD_AT) begin
        // long stall so the pipeline fills and in_tready drops
        held = 1'b1;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
      n_received++;
      if (awaited.size() == 0) begin
        $error("result transfer with nothing expected: victim_way %0d new_position %0d",
               out_tdata[3:0], out_tdata[8:4]);
        fail_count++;
      end else begin
        exp_o = awaited.pop_front();
        if (out_tdata[3:0] !== exp_o.victim) begin
          $error("victim_way mismatch: expected %0d, got %0d", exp_o.victim, out_tdata[3:0]);
          fail_count++;
        end
        if (out_tdata[8:4] !== exp_o.newpos) begin
          $error("new_position mismatch: expected %0d, got %0d",
                 exp_o.newpos, out_tdata[8:4]);
          fail_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [PV_W-1:0]   pv_tab  [PHASES];
    logic [INS_W-1:0]  ins_tab [PHASES];
    logic [OP_W-1:0]   op;
    logic [SIDX_W-1:0] set_idx;
    logic [WAYF_W-1:0] way;
    int                r;
    for (int s = 0; s < N_SETS; s++)
      for (int w = 0; w < N_WAYS; w++) begin
        way_pos[s][w] = '0;
        way_vld[s][w] = 1'b0;
      end

    // phase 0 runs on reset values; the rest cover register extremes and random settings
    pv_tab[0] = PV_RESET;               ins_tab[0] = INS_RESET;
    pv_tab[1] = '1;                     ins_tab[1] = 4'd15;  // every hit moves to 15
    pv_tab[2] = '0;                     ins_tab[2] = 4'd0;
    pv_tab[3] = 64'hFEDC_BA98_7654_3210; ins_tab[3] = 4'd13; // hit keeps positions up to 15
    pv_tab[4] = {$urandom, $urandom};   ins_tab[4] = INS_W'($urandom_range(0, 15));
    pv_tab[5] = 64'h7766_5544_3322_1100; ins_tab[5] = 4'd7;  // halve positions up to 15
    pv_tab[6] = {$urandom, $urandom};   ins_tab[6] = INS_W'($urandom_range(0, 15));

    // directed rows: op, set, way, typed, victim, new position
    add_row(OP_VICTIM,   0,  0, 1,  0,  0);  // nothing valid after reset
    add_row(OP_HIT,      0,  5, 1,  0,  0);  // hit on an invalid way
    add_row(OP_RESERVED, 63, 15, 1, 0,  0);  // unused opcode
    add_row(OP_FILL,     0,  0, 1,  0, 13);
    add_row(OP_FILL,     0, 15, 1,  0, 13);  // way 0 pushed down to 14
    add_row(OP_VICTIM,   0,  9, 1,  0,  0);  // way field ignored
    add_row(OP_HIT,      0,  0, 1,  0,  0);  // promote to 0, way 15 moves to 14
    add_row(OP_VICTIM,   0,  0, 1, 15,  0);
    add_row(OP_HIT,      0,  0, 1,  0,  0);  // new position not below old, nothing moves
    for (int w = 0; w < 10; w++)
      add_row(OP_FILL, 1, w, 0, 0, 0);       // way 0 ends well above 15
    add_row(OP_HIT,      1,  0, 0,  0,  0);  // high position uses the last entry
    add_row(OP_VICTIM,   1,  0, 0,  0,  0);
    add_row(OP_FILL,     1,  0, 0,  0,  0);  // refill of a valid way
    add_row(OP_HIT,     63, 15, 1,  0,  0);
    add_row(OP_VICTIM,  63, 15, 1,  0,  0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_op(dir_rows[i].op, dir_rows[i].set_idx, dir_rows[i].way,
              dir_rows[i].typed, dir_rows[i].outcome);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        program_regs(pv_tab[ph], ins_tab[ph]);
      end
      tx_burst = (ph == 2) || (ph == 5);
      rx_burst = (ph == 3) || (ph == 5);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = int'($urandom_range(0, 99));
        if (r < 40)      op = OP_HIT;
        else if (r < 68) op = OP_FILL;
        else if (r < 95) op = OP_VICTIM;
        else             op = OP_RESERVED;
        // a few hot sets so rows fill up and saturate, the rest anywhere
        if ($urandom_range(0, 3) == 0) set_idx = SIDX_W'($urandom_range(0, N_SETS - 1));
        else                           set_idx = SIDX_W'($urandom_range(0, 3));
        way = WAYF_W'($urandom_range(0, N_WAYS - 1));
        send_op(op, set_idx, way, 1'b0, '0);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ipv_cache_replacement_core] OK");
    end else begin
      $display("[ipv_cache_replacement_core] ERROR");
    end
    $finish;
  end

endmodule
